// File: design/vlsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlsp_pkg: shared types and constants of the length-prefixed string parser
// Result kinds, error codes, parse phases and the varint group shift table.
// ----------------------------------------------------------------------------
package vlsp_pkg;

    localparam int unsigned WordBits   = 64;
    localparam int unsigned GroupBits  = 7;
    localparam int unsigned ByteBits   = 8;
    // Ten continuation bytes overflow a 64-bit length
    localparam int unsigned MaxGroups  = 10;
    localparam int unsigned GroupCntW  = $clog2(MaxGroups);
    localparam int unsigned ShiftW     = $clog2(WordBits);

    localparam logic [GroupCntW-1:0] LastGroup = GroupCntW'(MaxGroups - 1);

    typedef logic [WordBits-1:0]  word_t;
    typedef logic [ByteBits-1:0]  byte_t;
    typedef logic [GroupCntW-1:0] group_cnt_t;
    typedef logic [ShiftW-1:0]    shift_t;

    typedef enum logic [1:0] {
        KIND_LENGTH = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_TOO_LONG   = 2'd1,
        ERR_VARINT_CUT = 2'd2,
        ERR_STRING_CUT = 2'd3
    } err_t;

    typedef enum logic {
        PH_LENGTH = 1'b0,
        PH_STRING = 1'b1
    } phase_t;

    // Bit position of a varint group: 7 bits per group
    function automatic shift_t group_shift(input group_cnt_t cnt);
        shift_t sh;
        case (cnt)
            4'd0:    sh = 6'd0;
            4'd1:    sh = 6'd7;
            4'd2:    sh = 6'd14;
            4'd3:    sh = 6'd21;
            4'd4:    sh = 6'd28;
            4'd5:    sh = 6'd35;
            4'd6:    sh = 6'd42;
            4'd7:    sh = 6'd49;
            4'd8:    sh = 6'd56;
            4'd9:    sh = 6'd63;
            default: sh = 6'd0;
        endcase
        return sh;
    endfunction

endpackage
`default_nettype wire

// File: design/vlsp_intf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlsp_intf: stream channels of the length-prefixed string parser
// Byte channel into the parser and result channel out of it, valid/ready.
// ----------------------------------------------------------------------------
interface vlsp_byte_if;
    logic                  valid;
    logic                  ready;
    vlsp_pkg::byte_t       in_byte;
    logic                  end_of_buffer;

    modport source (output valid, output in_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface vlsp_result_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    vlsp_pkg::word_t       length_value;
    vlsp_pkg::byte_t       text_byte;
    logic [1:0]            error_code;
    logic                  last_of_string;

    modport source (output valid, output kind, output length_value, output text_byte,
                    output error_code, output last_of_string, input ready);
    modport sink   (input valid, input kind, input length_value, input text_byte,
                    input error_code, input last_of_string, output ready);
endinterface
`default_nettype wire

// File: design/varint_length_string_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// varint_length_string_parser_core: LEB128 length-prefixed string parser
// Decodes an unsigned LEB128 length, then streams that many string bytes,
// flagging over-long varints and buffers that end too early.
// ----------------------------------------------------------------------------
// Each result is registered: it appears on the result channel in the cycle after its byte is taken.
// Throughput: one byte per cycle unless the result register stalls; the varint
// shift-or and the 64-bit count-down of remaining string bytes are combinational.
// A stalled result register holds back the byte channel until it drains.
// Reset returns the parser to the length phase with an empty result register.
module varint_length_string_parser_core (
    input  wire              clk,
    input  wire              rst_n,
    vlsp_byte_if.sink        bytes,
    vlsp_result_if.source    results
);

    // Parse state
    vlsp_pkg::phase_t     phase_reg, phase_next;
    vlsp_pkg::word_t      acc_reg, acc_next;
    vlsp_pkg::group_cnt_t grp_reg, grp_next;
    vlsp_pkg::word_t      remaining_reg, remaining_next;

    // Result register
    logic                 res_valid_reg;
    vlsp_pkg::kind_t      kind_reg, kind_next;
    vlsp_pkg::word_t      length_reg, length_next;
    vlsp_pkg::byte_t      text_reg, text_next;
    vlsp_pkg::err_t       err_reg, err_next;
    logic                 last_reg, last_next;
    logic                 res_hit;

    logic                 accept;
    logic                 cont;
    vlsp_pkg::word_t      merged;
    logic                 rem_last;

    // Take a byte whenever the result register is empty or draining
    assign bytes.ready = !res_valid_reg || results.ready;
    assign accept      = bytes.valid && bytes.ready;

    assign cont     = bytes.in_byte[vlsp_pkg::ByteBits-1];
    assign merged   = acc_reg | (vlsp_pkg::word_t'(bytes.in_byte[vlsp_pkg::GroupBits-1:0])
                                 << vlsp_pkg::group_shift(grp_reg));
    assign rem_last = (remaining_reg[vlsp_pkg::WordBits-1:1] == '0);

    // Next state of the parser
    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        grp_next       = grp_reg;
        remaining_next = remaining_reg;
        case (phase_reg)
            vlsp_pkg::PH_LENGTH:
            begin
                acc_next = merged;
                grp_next = grp_reg + 1'b1;
                if (!cont)
                begin
                    acc_next = '0;
                    grp_next = '0;
                    if (merged != '0 && !bytes.end_of_buffer)
                    begin
                        phase_next     = vlsp_pkg::PH_STRING;
                        remaining_next = merged;
                    end
                end
                else if (grp_reg == vlsp_pkg::LastGroup || bytes.end_of_buffer)
                begin
                    acc_next = '0;
                    grp_next = '0;
                end
            end
            vlsp_pkg::PH_STRING:
            begin
                remaining_next = remaining_reg - 1'b1;
                if (rem_last || bytes.end_of_buffer)
                begin
                    phase_next     = vlsp_pkg::PH_LENGTH;
                    remaining_next = '0;
                end
            end
            default:
            begin
                phase_next = vlsp_pkg::PH_LENGTH;
            end
        endcase
    end

    // Result of the current byte
    always_comb
    begin
        res_hit     = 1'b0;
        kind_next   = vlsp_pkg::KIND_LENGTH;
        length_next = '0;
        text_next   = '0;
        err_next    = vlsp_pkg::ERR_NONE;
        last_next   = 1'b0;
        case (phase_reg)
            vlsp_pkg::PH_LENGTH:
            begin
                if (!cont)
                begin
                    res_hit = 1'b1;
                    if (merged == '0)
                    begin
                        last_next = 1'b1;
                    end
                    else if (bytes.end_of_buffer)
                    begin
                        kind_next = vlsp_pkg::KIND_ERROR;
                        err_next  = vlsp_pkg::ERR_STRING_CUT;
                    end
                    else
                    begin
                        length_next = merged;
                    end
                end
                else if (grp_reg == vlsp_pkg::LastGroup)
                begin
                    res_hit   = 1'b1;
                    kind_next = vlsp_pkg::KIND_ERROR;
                    err_next  = vlsp_pkg::ERR_TOO_LONG;
                end
                else if (bytes.end_of_buffer)
                begin
                    res_hit   = 1'b1;
                    kind_next = vlsp_pkg::KIND_ERROR;
                    err_next  = vlsp_pkg::ERR_VARINT_CUT;
                end
            end
            vlsp_pkg::PH_STRING:
            begin
                res_hit = 1'b1;
                if (rem_last)
                begin
                    kind_next = vlsp_pkg::KIND_TEXT;
                    text_next = bytes.in_byte;
                    last_next = 1'b1;
                end
                else if (bytes.end_of_buffer)
                begin
                    kind_next = vlsp_pkg::KIND_ERROR;
                    err_next  = vlsp_pkg::ERR_STRING_CUT;
                end
                else
                begin
                    kind_next = vlsp_pkg::KIND_TEXT;
                    text_next = bytes.in_byte;
                end
            end
            default:
            begin
                res_hit = 1'b0;
            end
        endcase
    end

    // Advance parse state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= vlsp_pkg::PH_LENGTH;
            acc_reg       <= '0;
            grp_reg       <= '0;
            remaining_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            grp_reg       <= grp_next;
            remaining_reg <= remaining_next;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            res_valid_reg <= accept && res_hit;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (accept && res_hit)
        begin
            kind_reg   <= kind_next;
            length_reg <= length_next;
            text_reg   <= text_next;
            err_reg    <= err_next;
            last_reg   <= last_next;
        end
    end

    assign results.valid          = res_valid_reg;
    assign results.kind           = kind_reg;
    assign results.length_value   = length_reg;
    assign results.text_byte      = text_reg;
    assign results.error_code     = err_reg;
    assign results.last_of_string = last_reg;

`ifndef SYNTHESIS
    a_string_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == vlsp_pkg::PH_STRING |-> remaining_reg != '0)
        else $error("string phase with no bytes remaining");

    a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
        grp_reg <= vlsp_pkg::LastGroup)
        else $error("varint group count out of range");

    a_group_clear_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == vlsp_pkg::PH_STRING |-> grp_reg == '0 && acc_reg == '0)
        else $error("varint state not cleared in string phase");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_hit |=> res_valid_reg)
        else $error("result of accepted byte not presented");

    a_error_coded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ((kind_reg == vlsp_pkg::KIND_ERROR) == (err_reg != vlsp_pkg::ERR_NONE)))
        else $error("error kind and error code disagree");
`endif

endmodule
`default_nettype wire

// File: tb/sv/varint_length_string_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_length_string_parser_core_tb: self-checking bench of the string parser
// Drives LEB128 length-prefixed strings, cut buffers, over-long varints and
// noise into the byte channel. An in-bench parser predicts every result, and
// each result transaction is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module varint_length_string_parser_core_tb;

    localparam int unsigned StallLimit = 2000;
    localparam int unsigned MaxVarintBytes = 10;

    typedef struct packed {
        vlsp_pkg::kind_t kind;
        vlsp_pkg::word_t length_value;
        vlsp_pkg::byte_t text_byte;
        vlsp_pkg::err_t  error_code;
        logic            last_of_string;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n;

    vlsp_byte_if   byte_ch ();
    vlsp_result_if res_ch ();

    varint_length_string_parser_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .results (res_ch)
    );

    // Parser state mirrored in the bench
    vlsp_pkg::phase_t pr_phase;
    vlsp_pkg::word_t  len_acc;
    logic [6:0]       grp_shift;
    vlsp_pkg::word_t  str_left;

    parse_result_t parse_results_q[$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int n_bytes = 0;
    int n_fail = 0;
    int n_len = 0;
    int n_text = 0;
    int n_err = 0;
    int n_holds = 0;
    int stall_cnt = 0;

    always #5 clk = ~clk;

    // Drop back to the length phase with a cleared accumulator
    function automatic void clear_parse();
        pr_phase  = vlsp_pkg::PH_LENGTH;
        len_acc   = '0;
        grp_shift = '0;
        str_left  = '0;
    endfunction

    // Advance the mirrored parser by one byte and queue the result it causes
    function automatic void parse_step(input vlsp_pkg::byte_t b, input logic eob);
        parse_result_t r;
        vlsp_pkg::word_t len;
        logic emit;
        r = '0;
        emit = 1'b1;
        if (pr_phase == vlsp_pkg::PH_LENGTH)
        begin
            // Payload bits pushed past bit 63 fall off the top
            if (grp_shift < vlsp_pkg::WordBits)
                len_acc = len_acc
                        | (vlsp_pkg::word_t'(b[vlsp_pkg::GroupBits-1:0]) << grp_shift);
            if (!b[vlsp_pkg::ByteBits-1])
            begin
                len = len_acc;
                clear_parse();
                if (len == '0)
                begin
                    r.kind = vlsp_pkg::KIND_LENGTH;
                    r.last_of_string = 1'b1;
                end
                else if (eob)
                begin
                    // Nonzero length with no bytes left in the buffer
                    r.kind = vlsp_pkg::KIND_ERROR;
                    r.error_code = vlsp_pkg::ERR_STRING_CUT;
                end
                else
                begin
                    pr_phase = vlsp_pkg::PH_STRING;
                    str_left = len;
                    r.kind = vlsp_pkg::KIND_LENGTH;
                    r.length_value = len;
                end
            end
            else
            begin
                grp_shift = grp_shift + 7'(vlsp_pkg::GroupBits);
                if (grp_shift >= vlsp_pkg::WordBits)
                begin
                    // Over-long varint wins over the end of the buffer
                    clear_parse();
                    r.kind = vlsp_pkg::KIND_ERROR;
                    r.error_code = vlsp_pkg::ERR_TOO_LONG;
                end
                else if (eob)
                begin
                    clear_parse();
                    r.kind = vlsp_pkg::KIND_ERROR;
                    r.error_code = vlsp_pkg::ERR_VARINT_CUT;
                end
                else
                begin
                    emit = 1'b0;
                end
            end
        end
        else
        begin
            if (str_left <= 1)
            begin
                clear_parse();
                r.kind = vlsp_pkg::KIND_TEXT;
                r.text_byte = b;
                r.last_of_string = 1'b1;
            end
            else if (eob)
            begin
                clear_parse();
                r.kind = vlsp_pkg::KIND_ERROR;
                r.error_code = vlsp_pkg::ERR_STRING_CUT;
            end
            else
            begin
                str_left = str_left - 1;
                r.kind = vlsp_pkg::KIND_TEXT;
                r.text_byte = b;
            end
        end
        if (emit)
            parse_results_q.push_back(r);
    endfunction

    // Send one byte transaction; called and returns at a falling edge
    task automatic send_byte(input vlsp_pkg::byte_t b, input logic eob);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(negedge clk);
        end
        byte_ch.valid         <= 1'b1;
        byte_ch.in_byte       <= b;
        byte_ch.end_of_buffer <= eob;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        parse_step(b, eob);
        n_bytes++;
        @(negedge clk);
    endtask

    // Hold the byte channel until every queued result has drained
    task automatic wait_for_drain();
        byte_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (parse_results_q.size() != 0);
        n_holds++;
    endtask

    // Encode a LEB128 length, optionally padded with redundant zero groups
    task automatic send_varint(input vlsp_pkg::word_t v, input int pad,
                               input logic eob_at_end);
        vlsp_pkg::byte_t grp[$];
        int i;
        do
        begin
            grp.push_back({1'b0, v[vlsp_pkg::GroupBits-1:0]});
            v = v >> vlsp_pkg::GroupBits;
        end
        while (v != '0);
        for (i = 0; i < pad && grp.size() < MaxVarintBytes; i++)
            grp.push_back(8'h00);
        for (i = 0; i < grp.size(); i++)
        begin
            if (i < grp.size() - 1)
                grp[i][vlsp_pkg::ByteBits-1] = 1'b1;
            send_byte(grp[i], eob_at_end && (i == grp.size() - 1));
        end
    endtask

    // Stream n random string bytes, the last one optionally ending the buffer
    task automatic send_text(input int n, input logic eob_last);
        int i;
        for (i = 0; i < n; i++)
            send_byte(vlsp_pkg::byte_t'($urandom), eob_last && (i == n - 1));
    endtask

    // One random record: mostly well-formed strings, the rest broken or noise
    task automatic send_random_record();
        int sel;
        int len_sel;
        int n;
        int i;
        vlsp_pkg::word_t len;
        logic eob;
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            len_sel = $urandom_range(99);
            if (len_sel < 70)
                len = vlsp_pkg::word_t'($urandom_range(8));
            else if (len_sel < 95)
                len = vlsp_pkg::word_t'($urandom_range(40, 9));
            else
                len = vlsp_pkg::word_t'($urandom_range(200, 41));
            eob = 1'($urandom_range(1));
            n = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
            if (len == '0)
            begin
                send_varint(len, n, eob);
            end
            else
            begin
                send_varint(len, n, 1'b0);
                send_text(int'(len), eob);
            end
        end
        else if (sel < 80)
        begin
            // String cut short by the end of the buffer
            if ($urandom_range(4) == 0)
                len = vlsp_pkg::word_t'({$urandom, $urandom}) | vlsp_pkg::word_t'(2);
            else
                len = vlsp_pkg::word_t'($urandom_range(40, 2));
            n = (len > 7) ? $urandom_range(6) : $urandom_range(int'(len) - 1);
            if (n == 0)
            begin
                send_varint(len, 0, 1'b1);
            end
            else
            begin
                send_varint(len, 0, 1'b0);
                send_text(n, 1'b1);
            end
        end
        else if (sel < 87)
        begin
            // Varint cut by the end of the buffer
            n = $urandom_range(MaxVarintBytes - 1, 1);
            for (i = 0; i < n; i++)
                send_byte({1'b1, 7'($urandom)}, i == n - 1);
        end
        else if (sel < 93)
        begin
            // Ten continuation bytes
            for (i = 0; i < MaxVarintBytes; i++)
                send_byte({1'b1, 7'($urandom)},
                          (i == MaxVarintBytes - 1) && ($urandom_range(1) == 1));
        end
        else
        begin
            // Noise, then a terminating byte at a buffer end to resync
            n = $urandom_range(8, 1);
            for (i = 0; i < n; i++)
                send_byte(vlsp_pkg::byte_t'($urandom), $urandom_range(3) == 0);
            send_byte({1'b0, 7'($urandom)}, 1'b1);
        end
    endtask

    // Zero lengths, a single-byte string and the widest 64-bit length
    task automatic test_length_encodings();
        int i;
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Nine full groups plus a tenth whose upper payload bits are dropped
        for (i = 0; i < MaxVarintBytes - 1; i++)
            send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    // Every error code, including the over-long varint at the buffer end
    task automatic test_error_cases();
        int i;
        send_byte(8'h05, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        for (i = 0; i < MaxVarintBytes - 1; i++)
            send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // Random records under one idle setting, with at least one full drain
    task automatic test_random_traffic(input int quota, input int src_pct,
                                       input int snk_pct);
        int start;
        logic held;
        start = n_bytes;
        held = 1'b0;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        while (n_bytes - start < quota)
        begin
            if ((!held && n_bytes - start >= quota / 2) || $urandom_range(49) == 0)
            begin
                wait_for_drain();
                held = 1'b1;
            end
            send_random_record();
        end
    endtask

    // Compare one result field, X and Z included
    task automatic check_field(input string name, input vlsp_pkg::word_t want,
                               input vlsp_pkg::word_t got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endtask

    // Receiver stalls, changed at the falling edge
    always @(negedge clk)
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

    // Check each result transaction against the oldest queued result
    always @(posedge clk)
    begin
        parse_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (parse_results_q.size() == 0)
            begin
                $error("unexpected result: kind %0d", res_ch.kind);
                n_fail++;
            end
            else
            begin
                want = parse_results_q.pop_front();
                check_field("kind", vlsp_pkg::word_t'(want.kind),
                            vlsp_pkg::word_t'(res_ch.kind));
                check_field("length_value", want.length_value, res_ch.length_value);
                check_field("text_byte", vlsp_pkg::word_t'(want.text_byte),
                            vlsp_pkg::word_t'(res_ch.text_byte));
                check_field("error_code", vlsp_pkg::word_t'(want.error_code),
                            vlsp_pkg::word_t'(res_ch.error_code));
                check_field("last_of_string", vlsp_pkg::word_t'(want.last_of_string),
                            vlsp_pkg::word_t'(res_ch.last_of_string));
                case (want.kind)
                    vlsp_pkg::KIND_LENGTH: n_len++;
                    vlsp_pkg::KIND_TEXT:   n_text++;
                    default:               n_err++;
                endcase
            end
        end
    end

    // End the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= StallLimit)
            begin
                $display("timeout: no transaction for %0d cycles", StallLimit);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        byte_ch.valid         = 1'b0;
        byte_ch.in_byte       = '0;
        byte_ch.end_of_buffer = 1'b0;
        res_ch.ready          = 1'b0;
        clear_parse();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_idle_pct = 24;
        snk_idle_pct = 47;
        test_length_encodings();
        test_error_cases();
        test_random_traffic(360, 24, 47);
        test_random_traffic(360, 47, 24);
        test_random_traffic(350, 0, 0);

        // Drain the result channel, then idle before printing the summary
        byte_ch.valid <= 1'b0;
        while (parse_results_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        $display("covered %0d bytes under three stall mixes with %0d full drains",
                 n_bytes, n_holds);
        $display("checked %0d lengths, %0d string bytes, %0d errors; %0d mismatches",
                 n_len, n_text, n_err, n_fail);
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
design/vlsp_pkg.sv
design/vlsp_intf.sv
design/varint_length_string_parser_core.sv
tb/sv/varint_length_string_parser_core_tb.sv
